// ===== rtl/mirt_pkg.sv =====
package mirt_pkg;

  localparam int TABLE_DEPTH_DEF    = 64;
  localparam int JOB_INDEX_BITS_DEF = 8;
  localparam int CNT_W              = 16;
  localparam logic [CNT_W-1:0] INDEX_LIMIT_RST = 16'hFFFE;

  typedef enum logic [1:0] {
    K_REGISTER = 2'd0,
    K_RESOLVE  = 2'd1,
    K_RELEASE  = 2'd2,
    K_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_NAME   = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_REG_CHK,
    S_REG_SCAN,
    S_SCAN,
    S_CLEAR,
    S_FIN
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] job_number;
    logic [31:0] query_id;
    logic [31:0] name_handle;
    logic        name_present;
  } req_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [31:0] result_name;
    status_t     status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] name;
    logic [31:0] job;
  } entry_t;

endpackage

// ===== rtl/mark_id_registry_table.sv =====
// Mark id registry table.
// Channels: req (valid/ready, one operation per transfer), rsp (valid/ready,
// exactly one result per operation), cfg (valid/ready, writes index_limit;
// always ready, write only while no operation is in flight).
// One operation at a time: req_ready is high only while the sequencer idles.
// Steps from the req transfer to rsp_valid, TABLE_DEPTH = N, 2^JOB_INDEX_BITS = J:
//   register: read and check the job counter, then probe entries until a free one (up to N);
//             no probing when no name is given or when the counter is exhausted
//   resolve:  up to N entries compared, one entry per cycle, stops on a hit
//   release:  all N entries compared
//   clear:    all J slots of the job counter memory swept, one slot per cycle
// The entry memory has one read port, so scans run one entry per cycle.
// Reset: rst clears all flags and starts a sweep of the job counter
// memory; req_ready stays low until it ends. index_limit returns to 65534.
// A finished result sits in the rsp register; if the receiver stalls, the
// next result waits in the sequencer and the block accepts no new operation.
module mark_id_registry_table #(
  parameter int TABLE_DEPTH    = mirt_pkg::TABLE_DEPTH_DEF,
  parameter int JOB_INDEX_BITS = mirt_pkg::JOB_INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  mirt_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output mirt_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mirt_pkg::CNT_W-1:0] cfg_data
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int JW   = JOB_INDEX_BITS;
  localparam int CW   = mirt_pkg::CNT_W;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  mirt_pkg::state_t state, state_next;
  mirt_pkg::req_t   op, op_next;
  mirt_pkg::rsp_t   res, res_next, rsp_next;
  logic             rsp_valid_next;

  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] cmp_idx;
  logic          cmp_ok, cmp_ok_next;
  logic [JW-1:0] sweep, sweep_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] index_limit;

  logic [TABLE_DEPTH-1:0] live;
  logic [TABLE_DEPTH-1:0] used;

  mirt_pkg::entry_t ent_mem [TABLE_DEPTH];
  mirt_pkg::entry_t ent_q;
  logic [CW-1:0]    cnt_mem [2**JW];
  logic [CW-1:0]    cnt_q;

  logic          ent_we, set_live, take, drop, clr_all;
  logic          cnt_we;
  logic [JW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_limit <= mirt_pkg::INDEX_LIMIT_RST;
    end else if (cfg_valid) begin
      index_limit <= cfg_data;
    end
  end

  // entry and job counter memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[idx] <= '{id: {op.job_number[CW-1:0], cnt},
                        name: op.name_handle,
                        job: op.job_number};
    end
    ent_q <= ent_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[req.job_number[JW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      live <= '0;
      used <= '0;
    end else begin
      if (set_live) begin
        live[idx] <= 1'b1;
        used[idx] <= 1'b0;
      end
      if (take) begin
        used[cmp_idx] <= 1'b1;
      end
      if (drop) begin
        live[cmp_idx] <= 1'b0;
        used[cmp_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mirt_pkg::S_INIT;
      sweep     <= '0;
      cmp_ok    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      cmp_ok    <= cmp_ok_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    res     <= res_next;
    rsp     <= rsp_next;
    idx     <= idx_next;
    cmp_idx <= idx;
    cnt     <= cnt_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    idx_next       = idx;
    sweep_next     = sweep;
    cmp_ok_next    = 1'b0;
    cnt_next       = cnt;
    req_ready      = 1'b0;
    ent_we         = 1'b0;
    set_live       = 1'b0;
    take           = 1'b0;
    drop           = 1'b0;
    clr_all        = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = op.job_number[JW-1:0];
    cnt_wdata      = '0;
    unique case (state)
      mirt_pkg::S_INIT, mirt_pkg::S_CLEAR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = sweep;
        sweep_next = sweep + 1'b1;
        if (&sweep) begin
          state_next = (state == mirt_pkg::S_INIT) ? mirt_pkg::S_IDLE : mirt_pkg::S_FIN;
        end
      end
      mirt_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next    = req;
          idx_next   = '0;
          sweep_next = '0;
          res_next   = '{result_id: '0, result_name: '0, status: mirt_pkg::ST_OK};
          unique case (req.kind)
            mirt_pkg::K_REGISTER: begin
              if (!req.name_present) begin
                res_next.status = mirt_pkg::ST_NO_NAME;
                state_next      = mirt_pkg::S_FIN;
              end else begin
                state_next = mirt_pkg::S_REG_CHK;
              end
            end
            mirt_pkg::K_RESOLVE: begin
              state_next = mirt_pkg::S_SCAN;
            end
            mirt_pkg::K_RELEASE: begin
              cnt_we     = 1'b1;
              cnt_waddr  = req.job_number[JW-1:0];
              state_next = mirt_pkg::S_SCAN;
            end
            mirt_pkg::K_CLEAR: begin
              clr_all    = 1'b1;
              state_next = mirt_pkg::S_CLEAR;
            end
          endcase
        end
      end
      mirt_pkg::S_REG_CHK: begin
        if (cnt_q >= index_limit) begin
          res_next.status = mirt_pkg::ST_EXHAUSTED;
          state_next      = mirt_pkg::S_FIN;
        end else begin
          cnt_next   = cnt_q;
          state_next = mirt_pkg::S_REG_SCAN;
        end
      end
      mirt_pkg::S_REG_SCAN: begin
        if (!live[idx] || used[idx]) begin
          ent_we             = 1'b1;
          set_live           = 1'b1;
          cnt_we             = 1'b1;
          cnt_wdata          = cnt + 1'b1;
          res_next.result_id = {op.job_number[CW-1:0], cnt};
          state_next         = mirt_pkg::S_FIN;
        end else if (idx == LAST) begin
          res_next.status = mirt_pkg::ST_FULL;
          state_next      = mirt_pkg::S_FIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      mirt_pkg::S_SCAN: begin
        cmp_ok_next = 1'b1;
        if (idx != LAST) begin
          idx_next = idx + 1'b1;
        end
        if (cmp_ok) begin
          if (op.kind == mirt_pkg::K_RESOLVE) begin
            if (live[cmp_idx] && !used[cmp_idx] && ent_q.id == op.query_id) begin
              take                 = 1'b1;
              res_next.result_name = ent_q.name;
              state_next           = mirt_pkg::S_FIN;
            end else if (cmp_idx == LAST) begin
              res_next.status = mirt_pkg::ST_NOT_FOUND;
              state_next      = mirt_pkg::S_FIN;
            end
          end else begin
            if (live[cmp_idx] && ent_q.job == op.job_number) begin
              drop = 1'b1;
            end
            if (cmp_idx == LAST) begin
              state_next = mirt_pkg::S_FIN;
            end
          end
        end
      end
      mirt_pkg::S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = mirt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mirt_pkg::S_IDLE;
      end
    endcase
  end

  // a consumed entry is always a live one
  assert property (@(posedge clk) disable iff (rst) (used & ~live) == '0)
    else $error("used flag set on an entry that is not live");

  assert property (@(posedge clk) disable iff (rst)
    state == mirt_pkg::S_REG_SCAN |-> cnt < index_limit)
    else $error("slot search running with an exhausted counter");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_name != '0 |-> rsp.status == mirt_pkg::ST_OK)
    else $error("name returned with a failure status");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != mirt_pkg::ST_OK |-> rsp.result_id == '0)
    else $error("id returned with a failure status");

endmodule
